@@ hdl/phtn_pkg.sv @@
`timescale 1ns / 1ps
// phtn_pkg: command codes, register indexes and fixed field widths
// for the PC-sampling histogram block. No dependencies.
package phtn_pkg;

  localparam int MODE_W    = 2;
  localparam int PC_W      = 32;
  localparam int CNT_W     = 32;
  localparam int RANK_W    = 4;
  localparam int IDX_OUT_W = 12;
  localparam int ENTRIES_W = 13;
  localparam int CFG_IDX_W = 8;
  localparam int CFG_DAT_W = 32;

  // request modes
  localparam logic [MODE_W-1:0] MODE_START  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_SAMPLE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_STOP   = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_TEXT_BASE = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ENTRIES   = 8'd1;

  localparam logic [PC_W-1:0]      TEXT_BASE_RST = 32'h0000_8000;
  localparam logic [ENTRIES_W-1:0] ENTRIES_RST   = 13'd4096;

  // byte offset past the base that maps to index 0; lower PCs map there too
  localparam logic [PC_W+1:0] PC_OFFSET = 34'd8;

endpackage

@@ hdl/phtn_ram.sv @@
`timescale 1ns / 1ps
// phtn_ram: generic single-write, single-read RAM with registered read.
// No dependencies.
module phtn_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hdl/pc_sample_histogram_top_n_core.sv @@
`timescale 1ns / 1ps
// Start request: every counter in the RAM is cleared, one counter cleared per cycle;
//   sample request: index calc, read, saturating write-back (skipped if out of range).
// Stop request: each counter in use is read and checked in turn, then each nonzero one
//   is ranked on the shared comparator; then one result per cycle while out_stall allows.
// One request in flight at a time; in_stall is high until it finishes.
// Reset: sequencer, running flag, list fill, output valid and config regs reset;
//   counter RAM is not reset, it is always cleared by a start before it is read.
// pc_sample_histogram_top_n_core: top level, uses phtn_pkg and phtn_ram.
module pc_sample_histogram_top_n_core
  import phtn_pkg::*;
#(
  parameter int NUM_ENTRIES = 4096,
  parameter int TOP_N       = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // request channel
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [MODE_W-1:0]    in_mode,
  input  logic [PC_W-1:0]      in_sample_pc,
  // result channel
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [RANK_W-1:0]    out_rank,
  output logic [IDX_OUT_W-1:0] out_instr_index,
  output logic [CNT_W-1:0]     out_hit_count,
  output logic                 out_last,
  output logic                 out_empty_res,
  // configuration write channel
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_wdata
);

  localparam int AW = $clog2(NUM_ENTRIES);
  localparam int KW = (TOP_N > 1) ? $clog2(TOP_N) : 1;
  localparam int FW = $clog2(TOP_N + 1);
  localparam logic [AW:0]   NE_W   = (AW+1)'(NUM_ENTRIES);
  localparam logic [AW-1:0] LAST_A = AW'(NUM_ENTRIES - 1);
  localparam logic [FW-1:0] TOPN_W = FW'(TOP_N);
  localparam logic [FW-1:0] TOPN_M1 = FW'(TOP_N - 1);

  // sequencer codes
  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_CLR      = 4'd1;
  localparam logic [3:0] S_SA       = 4'd2;
  localparam logic [3:0] S_SB       = 4'd3;
  localparam logic [3:0] S_SC       = 4'd4;
  localparam logic [3:0] S_SCAN_RD  = 4'd5;
  localparam logic [3:0] S_SCAN_CHK = 4'd6;
  localparam logic [3:0] S_HEAD     = 4'd7;
  localparam logic [3:0] S_TAIL     = 4'd8;
  localparam logic [3:0] S_SRCH     = 4'd9;
  localparam logic [3:0] S_INS      = 4'd10;
  localparam logic [3:0] S_RPT      = 4'd11;

  logic [3:0]           state_r, state_nxt;
  logic                 running_r, running_nxt;
  logic [PC_W-1:0]      base_r, base_nxt;
  logic [ENTRIES_W-1:0] entries_r, entries_nxt;
  logic [PC_W-1:0]      pc_r, pc_nxt;
  logic [PC_W+1:0]      diff_r, diff_nxt;
  logic [AW-1:0]        addr_r, addr_nxt;
  logic [AW-1:0]        clr_r, clr_nxt;
  logic [AW:0]          scan_r, scan_nxt;
  logic [CNT_W-1:0]     cand_cnt_r, cand_cnt_nxt;
  logic [AW-1:0]        cand_idx_r, cand_idx_nxt;
  logic [KW-1:0]        k_r, k_nxt;
  logic [FW-1:0]        pos_r, pos_nxt;
  logic [FW-1:0]        fill_r, fill_nxt;
  logic [CNT_W-1:0]     top_cnt_r [TOP_N];
  logic [CNT_W-1:0]     top_cnt_nxt [TOP_N];
  logic [AW-1:0]        top_idx_r [TOP_N];
  logic [AW-1:0]        top_idx_nxt [TOP_N];

  logic                 out_valid_r, out_valid_nxt;
  logic [RANK_W-1:0]    out_rank_r, out_rank_nxt;
  logic [IDX_OUT_W-1:0] out_idx_r, out_idx_nxt;
  logic [CNT_W-1:0]     out_cnt_r, out_cnt_nxt;
  logic                 out_last_r, out_last_nxt;
  logic                 out_empty_r, out_empty_nxt;

  // counter RAM port
  logic                 ram_we;
  logic [AW-1:0]        ram_waddr;
  logic [CNT_W-1:0]     ram_wdata;
  logic [AW-1:0]        ram_raddr;
  logic [CNT_W-1:0]     ram_rdata;

  logic                 in_acc;
  logic [AW:0]          active;
  logic [AW-1:0]        smp_addr;
  logic                 smp_in_range;
  logic [FW-1:0]        ins_end;
  logic                 ins_drop;
  logic                 slot_free;

  // shared comparator: candidate count against one list entry
  logic [CNT_W-1:0]     cmp_b;
  logic                 cmp_gt;
  logic                 cmp_eq;

  phtn_ram #(
    .WIDTH (CNT_W),
    .DEPTH (NUM_ENTRIES)
  ) u_cnt_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign in_acc    = in_valid && !in_stall;
  assign in_stall  = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;

  assign out_valid       = out_valid_r;
  assign out_rank        = out_rank_r;
  assign out_instr_index = out_idx_r;
  assign out_hit_count   = out_cnt_r;
  assign out_last        = out_last_r;
  assign out_empty_res   = out_empty_r;

  // entries in use, clipped to the RAM depth
  assign active = (32'(entries_r) > 32'(NUM_ENTRIES)) ? NE_W : (AW+1)'(entries_r);

  // below base+8 maps to index 0, else (pc-base-8)/4
  assign smp_addr     = diff_r[PC_W+1] ? '0 : diff_r[AW+1:2];
  assign smp_in_range = diff_r[PC_W+1] ? (active != '0)
                                       : ({2'b00, diff_r[PC_W-1:2]} < 32'(active));

  assign cmp_b  = top_cnt_r[k_r];
  assign cmp_gt = cand_cnt_r > cmp_b;
  assign cmp_eq = cand_cnt_r == cmp_b;

  assign ins_end   = (fill_r < TOPN_W) ? fill_r : TOPN_M1;
  assign ins_drop  = (pos_r >= fill_r) && (fill_r >= TOPN_W);
  assign slot_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt     = state_r;
    running_nxt   = running_r;
    base_nxt      = base_r;
    entries_nxt   = entries_r;
    pc_nxt        = pc_r;
    diff_nxt      = diff_r;
    addr_nxt      = addr_r;
    clr_nxt       = clr_r;
    scan_nxt      = scan_r;
    cand_cnt_nxt  = cand_cnt_r;
    cand_idx_nxt  = cand_idx_r;
    k_nxt         = k_r;
    pos_nxt       = pos_r;
    fill_nxt      = fill_r;
    top_cnt_nxt   = top_cnt_r;
    top_idx_nxt   = top_idx_r;
    out_valid_nxt = out_valid_r;
    out_rank_nxt  = out_rank_r;
    out_idx_nxt   = out_idx_r;
    out_cnt_nxt   = out_cnt_r;
    out_last_nxt  = out_last_r;
    out_empty_nxt = out_empty_r;
    ram_we        = 1'b0;
    ram_waddr     = addr_r;
    ram_wdata     = '0;
    ram_raddr     = addr_r;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_TEXT_BASE: base_nxt    = cfg_wdata;
        CFG_ENTRIES:   entries_nxt = cfg_wdata[ENTRIES_W-1:0];
        default: ;
      endcase
    end

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          case (in_mode)
            MODE_START: begin
              if (!running_r) begin
                running_nxt = 1'b1;
                clr_nxt     = '0;
                state_nxt   = S_CLR;
              end
            end
            MODE_SAMPLE: begin
              if (running_r) begin
                pc_nxt    = in_sample_pc;
                state_nxt = S_SA;
              end
            end
            MODE_STOP: begin
              if (running_r) begin
                running_nxt = 1'b0;
                fill_nxt    = '0;
                scan_nxt    = '0;
                state_nxt   = S_SCAN_RD;
              end
            end
            default: ;
          endcase
        end
      end

      // one counter zeroed per cycle
      S_CLR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_r;
        ram_wdata = '0;
        clr_nxt   = clr_r + 1'b1;
        if (clr_r == LAST_A) begin
          state_nxt = S_IDLE;
        end
      end

      S_SA: begin
        diff_nxt  = {2'b00, pc_r} - ({2'b00, base_r} + PC_OFFSET);
        state_nxt = S_SB;
      end

      S_SB: begin
        ram_raddr = smp_addr;
        addr_nxt  = smp_addr;
        state_nxt = smp_in_range ? S_SC : S_IDLE;
      end

      // saturating write-back
      S_SC: begin
        ram_we    = 1'b1;
        ram_waddr = addr_r;
        ram_wdata = (ram_rdata == '1) ? ram_rdata : ram_rdata + 1'b1;
        state_nxt = S_IDLE;
      end

      S_SCAN_RD: begin
        ram_raddr = scan_r[AW-1:0];
        if (scan_r >= active) begin
          k_nxt     = '0;
          state_nxt = S_RPT;
        end else begin
          state_nxt = S_SCAN_CHK;
        end
      end

      S_SCAN_CHK: begin
        cand_cnt_nxt = ram_rdata;
        cand_idx_nxt = scan_r[AW-1:0];
        scan_nxt     = scan_r + 1'b1;
        k_nxt        = '0;
        state_nxt    = (ram_rdata != '0) ? S_HEAD : S_SCAN_RD;
      end

      // at or above the head goes first
      S_HEAD: begin
        if (fill_r == '0 || cmp_gt || cmp_eq) begin
          pos_nxt   = '0;
          state_nxt = S_INS;
        end else begin
          k_nxt     = KW'(fill_r - 1'b1);
          state_nxt = S_TAIL;
        end
      end

      // at or below the tail goes to the end
      S_TAIL: begin
        if (!cmp_gt) begin
          pos_nxt   = fill_r;
          state_nxt = S_INS;
        end else begin
          k_nxt     = KW'(1);
          state_nxt = S_SRCH;
        end
      end

      // first entry not above the candidate; the tail bounds the walk
      S_SRCH: begin
        if (cmp_gt || cmp_eq) begin
          pos_nxt   = FW'(k_r);
          state_nxt = S_INS;
        end else begin
          k_nxt = k_r + 1'b1;
        end
      end

      S_INS: begin
        if (!ins_drop) begin
          for (int i = 0; i < TOP_N; i++) begin
            if (FW'(i) == pos_r) begin
              top_cnt_nxt[i] = cand_cnt_r;
              top_idx_nxt[i] = cand_idx_r;
            end else if (i > 0 && FW'(i) > pos_r && FW'(i) <= ins_end) begin
              top_cnt_nxt[i] = top_cnt_r[i-1];
              top_idx_nxt[i] = top_idx_r[i-1];
            end
          end
          if (fill_r < TOPN_W) begin
            fill_nxt = fill_r + 1'b1;
          end
        end
        state_nxt = S_SCAN_RD;
      end

      S_RPT: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          if (fill_r == '0) begin
            out_rank_nxt  = '0;
            out_idx_nxt   = '0;
            out_cnt_nxt   = '0;
            out_last_nxt  = 1'b1;
            out_empty_nxt = 1'b1;
            state_nxt     = S_IDLE;
          end else begin
            out_rank_nxt  = RANK_W'(k_r);
            out_idx_nxt   = IDX_OUT_W'(32'(top_idx_r[k_r]));
            out_cnt_nxt   = top_cnt_r[k_r];
            out_last_nxt  = (FW'(k_r) + 1'b1 == fill_r);
            out_empty_nxt = 1'b0;
            k_nxt         = k_r + 1'b1;
            if (FW'(k_r) + 1'b1 == fill_r) begin
              state_nxt = S_IDLE;
            end
          end
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      running_r   <= 1'b0;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
      base_r      <= TEXT_BASE_RST;
      entries_r   <= ENTRIES_RST;
    end else begin
      state_r     <= state_nxt;
      running_r   <= running_nxt;
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
      base_r      <= base_nxt;
      entries_r   <= entries_nxt;
    end
  end

  // datapath, no reset
  always_ff @(posedge clk) begin
    pc_r        <= pc_nxt;
    diff_r      <= diff_nxt;
    addr_r      <= addr_nxt;
    clr_r       <= clr_nxt;
    scan_r      <= scan_nxt;
    cand_cnt_r  <= cand_cnt_nxt;
    cand_idx_r  <= cand_idx_nxt;
    k_r         <= k_nxt;
    pos_r       <= pos_nxt;
    top_cnt_r   <= top_cnt_nxt;
    top_idx_r   <= top_idx_nxt;
    out_rank_r  <= out_rank_nxt;
    out_idx_r   <= out_idx_nxt;
    out_cnt_r   <= out_cnt_nxt;
    out_last_r  <= out_last_nxt;
    out_empty_r <= out_empty_nxt;
  end

  // list never grows past TOP_N
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= TOPN_W)
    else $error("top list fill exceeds TOP_N");

  // empty report is a single, final, zero item
  a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_empty_r) |-> (out_last_r && out_cnt_r == '0))
    else $error("empty result not flagged last or count nonzero");

  // a counter write-back only happens while running
  a_wb_running: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SC) |-> running_r)
    else $error("counter updated while stopped");

  // start while stopped launches the clearing sweep
  a_start_clr: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_mode == MODE_START && !running_r) |=> (state_r == S_CLR && running_r))
    else $error("start request did not begin clearing");

endmodule
